FILE: rtl/srp_pkg.sv
// shared constants and types for the stereo rotating-pole filter
package srp_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int POLE_SLOTS         = 6;
  localparam int SLOT_W             = $clog2(POLE_SLOTS);
  localparam int POLE_W             = 32;
  localparam int SET_W              = 17;

  localparam int Q16_ONE        = 65536;
  localparam int HALF_Q16       = 32768;
  localparam int ROUND_UP_Q16   = 65535;
  localparam int SENTINEL_Q16   = 65536000;
  localparam int RESET_WEIGHT   = 218;
  localparam int WEIGHT_DEN_OFF = 301 * 65536;
  localparam int NONLIN_GAIN    = 6;
  localparam int PREV_W         = 26;

  localparam int CBRT_STEPS = 18;
  localparam int CBRT_HI    = 1 << 18;
  localparam int CBRT_SHIFT = 32;
  localparam int TRIM_K     = 3;
  localparam int TRIM_SHIFT = 15;

  localparam int MUL_A_W   = 40;
  localparam int MUL_B_MIN = 18;
  localparam int DIV_D_W   = 27;
  localparam int DIV_N_MIN = 43;

  typedef enum logic [1:0] {
    CFG_LOWPASS  = 2'd0,
    CFG_HIGHPASS = 2'd1,
    CFG_NONLIN   = 2'd2,
    CFG_WET      = 2'd3
  } cfg_idx_e;

endpackage

FILE: rtl/srp_if.sv
// input and output item channels of the stereo rotating-pole filter
interface srp_in_if import srp_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_start;

  modport source (output valid, left_in, right_in, block_start, input ready);
  modport sink (input valid, left_in, right_in, block_start, output ready);
endinterface

interface srp_out_if import srp_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

FILE: rtl/stereo_rotating_pole_iir_filter_core.sv
// top level: sequencer, pole store and shared serial arithmetic of the stereo filter
//
// Items enter on in_i (valid/ready) carrying a left and a right sample and a
// block_start flag; one result item per input leaves on out_o. Settings are
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
// them only while the block is idle, and the block itself does not enforce
// this. One item is worked on at a time: every multiply goes through a
// bit-serial shift-add unit and every divide through a bit-serial restoring
// divider. block_start adds three weight divides. The first item after reset
// or after a nonlinearity write also reruns the cube-root search for the
// output trim (18 steps of two multiplies plus a divide).
// The result sits in an output register, so the next item is taken while a
// stalled result waits; the block holds off a new item while it works on one,
// and when it has a second result ready and the first is still not taken.
// Reset clears the poles (by valid bits), the smoothing state, the phase and
// the settings to their defaults; no clearing pass is needed.
module stereo_rotating_pole_iir_filter_core import srp_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  srp_in_if.sink           in_i,
  srp_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [SET_W-1:0] cfg_data_i
);
  localparam int SB     = SAMPLE_BITS;
  localparam int CF     = COEF_FRAC_BITS;
  localparam int MB_W   = (CF + 3 > MUL_B_MIN) ? CF + 3 : MUL_B_MIN;
  localparam int MP_W   = MUL_A_W + MB_W;
  localparam int DN_W   = (SB + 16 > DIV_N_MIN) ? SB + 16 : DIV_N_MIN;
  localparam int SH     = SB - 1 - CF;
  localparam int SH_R   = (SH > 0) ? SH : 0;
  localparam int SH_L   = (SH < 0) ? -SH : 0;
  localparam int RND    = (SH > 0) ? (1 << (SH_R - 1)) : 0;
  localparam int R2_W   = SB + SH_L + 1;
  localparam int SC_W   = CF + 2;
  localparam int TR_W   = CF + 1;
  localparam int PS_W   = MP_W + 1;
  localparam int F_W    = 34;
  localparam int ADDR_W = 2 + SLOT_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_TGT    = 12'b000000000010,
    ST_CUBE   = 12'b000000000100,
    ST_TRIM   = 12'b000000001000,
    ST_WGT    = 12'b000000010000,
    ST_SMOOTH = 12'b000000100000,
    ST_DIEL   = 12'b000001000000,
    ST_AMT    = 12'b000010000000,
    ST_PRD    = 12'b000100000000,
    ST_POLE   = 12'b001000000000,
    ST_MIX    = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_e;

  state_e state_q;
  logic               run_q, dirty_q, out_valid_q, ch_q, cph_q;
  logic [1:0]         k_q;
  logic [2:0]         p_q, phase_q, phase_nx;
  logic [4:0]         it_q;
  logic [SET_W-1:0]   set_q [4];
  logic [16:0]        base_q [3];
  logic [PREV_W-1:0]  prev_q [3];
  logic [16:0]        wt_q [3];
  logic [DEPTH-1:0]   vld_q;

  logic signed [SB-1:0]     xs_q [2];
  logic                     bs_q;
  logic [16:0]              tgt_q [2];
  logic [18:0]              lo_q, hi_q;
  logic [35:0]              sq_q;
  logic [TR_W-1:0]          trim_q;
  logic [SC_W-1:0]          sc_q;
  logic [SC_W-1:0]          amt_q [2];
  logic signed [POLE_W-1:0] xcur_q, rd_q;
  logic                     rdv_q;
  logic signed [F_W-1:0]    f_q;
  logic signed [MP_W-1:0]   acc_q;
  logic signed [SB-1:0]     res_q [2];
  logic signed [SB-1:0]     out_l_q, out_r_q;
  logic signed [POLE_W-1:0] mem [DEPTH];

  logic                     mul_start, mul_done, div_start, div_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MB_W-1:0]           mul_b;
  logic signed [MP_W-1:0]    mul_p;
  logic [DN_W-1:0]           div_num, div_quo;
  logic [DIV_D_W-1:0]        div_den;

  logic [16:0]              kn [4];
  logic [16:0]              tg [3];
  logic [16:0]              omk;
  logic [18:0]              n16;
  logic [17:0]              mid;
  logic [PREV_W-1:0]        dsel;
  logic [DIV_D_W-1:0]       wden;
  logic [42:0]              wnum;
  logic signed [17:0]       sdl;
  logic [16:0]              smag, sstep, snew;
  logic signed [SB:0]       xe;
  logic [SB-1:0]            xmag;
  logic [R2_W-1:0]          r2;
  logic [SC_W-1:0]          r2c, sc_new;
  logic [1:0]               sect;
  logic                     which;
  logic [SLOT_W-1:0]        slot, rot3;
  logic [ADDR_W-1:0]        addr;
  logic signed [POLE_W-1:0] ycur, newy, xnext;
  logic signed [POLE_W:0]   diff, xdiff;
  logic signed [PS_W-1:0]   ps;
  logic signed [PS_W:0]     msum;
  logic signed [SB-1:0]     mres;
  logic                     in_acc, out_acc, out_load, after_bs;

  function automatic logic signed [POLE_W-1:0] sat_pole(input logic signed [PS_W-1:0] v);
    logic signed [PS_W-1:0] hi, lo;
    hi = PS_W'((64'sd1 <<< (POLE_W - 1)) - 64'sd1);
    lo = -hi - PS_W'(1);
    if (v > hi) return hi[POLE_W-1:0];
    else if (v < lo) return lo[POLE_W-1:0];
    else return v[POLE_W-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_out(input logic signed [PS_W:0] v);
    logic signed [PS_W:0] hi, lo;
    hi = (PS_W+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
    lo = -hi - (PS_W+1)'(1);
    if (v > hi) return hi[SB-1:0];
    else if (v < lo) return lo[SB-1:0];
    else return v[SB-1:0];
  endfunction

  srp_mul #(.BW(MB_W)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  srp_div #(.NW(DN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_valid_q && out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign after_bs    = bs_q;

  // wet target and nonlinearity divisor follow the settings live
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kn[i] = (set_q[i] > SET_W'(Q16_ONE)) ? 17'(Q16_ONE) : set_q[i];
    end
    tg[0] = tgt_q[0];
    tg[1] = tgt_q[1];
    tg[2] = kn[CFG_WET];
    omk   = 17'(Q16_ONE) - kn[CFG_NONLIN];
    n16   = 19'(Q16_ONE) + 19'(NONLIN_GAIN) * 19'(omk);
    mid   = 18'((20'(lo_q) + 20'(hi_q)) >> 1);
  end

  // weight, smoothing and dielectric scale arithmetic
  always_comb begin
    dsel  = (prev_q[k_q] > PREV_W'(tg[k_q])) ? prev_q[k_q] - PREV_W'(tg[k_q])
                                            : PREV_W'(tg[k_q]) - prev_q[k_q];
    wden  = DIV_D_W'(dsel) + DIV_D_W'(WEIGHT_DEN_OFF);
    wnum  = ((43'(dsel) + 43'(Q16_ONE)) << 16) + 43'(wden >> 1);
    sdl   = $signed({1'b0, tg[k_q]}) - $signed({1'b0, base_q[k_q]});
    smag  = 17'(sdl < 0 ? -sdl : sdl);
    sstep = 17'((mul_p + MP_W'(ROUND_UP_Q16)) >>> 16);
    snew  = (sdl < 0) ? base_q[k_q] - sstep : base_q[k_q] + sstep;
    xe    = (SB+1)'(xs_q[ch_q]);
    xmag  = SB'(xe < 0 ? -xe : xe);
    r2    = ((R2_W'(div_quo[SB-1:0]) + R2_W'(RND)) >> SH_R) << SH_L;
    r2c   = SC_W'(r2);
    if (xs_q[ch_q] < 0) sc_new = SC_W'(1 << CF) + r2c;
    else if (r2c > SC_W'(1 << CF)) sc_new = r2c - SC_W'(1 << CF);
    else sc_new = SC_W'(1 << CF) - r2c;
  end

  // pole slot rotation and pole update
  always_comb begin
    sect  = 2'(p_q >> 1);
    which = p_q[0];
    unique case (phase_q)
      3'd1, 3'd4: rot3 = SLOT_W'(1);
      3'd2, 3'd5: rot3 = SLOT_W'(2);
      default:    rot3 = '0;
    endcase
    unique case (sect)
      2'd0:    slot = '0;
      2'd1:    slot = phase_q[0] ? SLOT_W'(2) : SLOT_W'(1);
      default: slot = SLOT_W'(3) + rot3;
    endcase
    addr     = {ch_q, which, slot};
    ycur     = rdv_q ? rd_q : '0;
    diff     = (POLE_W+1)'(xcur_q) - (POLE_W+1)'(ycur);
    ps       = (PS_W'(ycur) <<< CF) + PS_W'(mul_p);
    newy     = sat_pole((ps + (PS_W'(1) <<< (CF - 1))) >>> CF);
    xdiff    = (POLE_W+1)'(xcur_q) - (POLE_W+1)'(newy);
    if (xdiff[POLE_W] != xdiff[POLE_W-1])
      xnext = xdiff[POLE_W] ? {1'b1, {(POLE_W-1){1'b0}}} : {1'b0, {(POLE_W-1){1'b1}}};
    else
      xnext = xdiff[POLE_W-1:0];
    msum     = (PS_W+1)'(acc_q) + (PS_W+1)'(mul_p);
    mres     = sat_out((msum + (PS_W+1)'(HALF_Q16)) >>> 16);
    phase_nx = (phase_q >= 3'd5) ? 3'd0 : phase_q + 3'd1;
  end

  // operands of the shared units
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_TGT: begin
        mul_start = !run_q;
        mul_a     = MUL_A_W'(kn[k_q]);
        mul_b     = MB_W'(kn[k_q]);
      end
      ST_CUBE: begin
        mul_start = !run_q;
        mul_a     = cph_q ? MUL_A_W'(sq_q) : MUL_A_W'(mid);
        mul_b     = MB_W'(mid);
      end
      ST_TRIM: begin
        div_start = !run_q;
        div_num   = DN_W'(TRIM_K) << (CF + TRIM_SHIFT);
        div_den   = DIV_D_W'(lo_q);
      end
      ST_WGT: begin
        div_start = !run_q;
        div_num   = DN_W'(wnum);
        div_den   = wden;
      end
      ST_SMOOTH: begin
        mul_start = !run_q;
        mul_a     = MUL_A_W'(smag);
        mul_b     = MB_W'(wt_q[k_q]);
      end
      ST_DIEL: begin
        div_start = !run_q;
        div_num   = (DN_W'(xmag) << 16) + DN_W'(n16 >> 1);
        div_den   = DIV_D_W'(n16);
      end
      ST_AMT: begin
        mul_start = !run_q;
        mul_a     = MUL_A_W'(base_q[k_q]);
        mul_b     = MB_W'(sc_q);
      end
      ST_POLE: begin
        mul_start = !run_q;
        mul_a     = MUL_A_W'(diff);
        mul_b     = which ? MB_W'(amt_q[0]) : MB_W'(amt_q[1]);
      end
      ST_MIX: begin
        mul_start = !run_q;
        unique case (k_q)
          2'd0: begin
            mul_a = MUL_A_W'(xcur_q);
            mul_b = MB_W'(trim_q);
          end
          2'd1: begin
            mul_a = MUL_A_W'(xs_q[ch_q]);
            mul_b = MB_W'(17'(Q16_ONE) - base_q[2]);
          end
          default: begin
            mul_a = MUL_A_W'(f_q);
            mul_b = MB_W'(base_q[2]);
          end
        endcase
      end
      default: ;
    endcase
  end

  // sequencer and smoothing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      dirty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      ch_q        <= 1'b0;
      cph_q       <= 1'b0;
      k_q         <= '0;
      p_q         <= '0;
      it_q        <= '0;
      phase_q     <= '0;
      vld_q       <= '0;
      set_q[CFG_LOWPASS]  <= SET_W'(Q16_ONE);
      set_q[CFG_HIGHPASS] <= '0;
      set_q[CFG_NONLIN]   <= '0;
      set_q[CFG_WET]      <= SET_W'(Q16_ONE);
      base_q[0] <= 17'(Q16_ONE);
      base_q[1] <= '0;
      base_q[2] <= 17'(Q16_ONE);
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= PREV_W'(SENTINEL_Q16);
        wt_q[i]   <= 17'(RESET_WEIGHT);
      end
    end else begin
      if (cfg_we_i) begin
        set_q[cfg_idx_i] <= cfg_data_i;
        if (cfg_idx_i == CFG_NONLIN) dirty_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_TGT;
            k_q     <= '0;
            run_q   <= 1'b0;
          end
        end
        ST_TGT: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q <= 1'b0;
            if (k_q == 2'd1) begin
              k_q <= '0;
              if (dirty_q) begin
                state_q <= ST_CUBE;
                it_q    <= '0;
                cph_q   <= 1'b0;
              end else begin
                state_q <= after_bs ? ST_WGT : ST_SMOOTH;
              end
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_CUBE: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q <= 1'b0;
            cph_q <= !cph_q;
            if (cph_q) begin
              it_q <= it_q + 5'd1;
              if (it_q == 5'(CBRT_STEPS - 1)) state_q <= ST_TRIM;
            end
          end
        end
        ST_TRIM: begin
          if (!run_q) run_q <= 1'b1;
          else if (div_done) begin
            run_q   <= 1'b0;
            dirty_q <= 1'b0;
            state_q <= after_bs ? ST_WGT : ST_SMOOTH;
          end
        end
        ST_WGT: begin
          if (!run_q) run_q <= 1'b1;
          else if (div_done) begin
            run_q        <= 1'b0;
            wt_q[k_q]    <= div_quo[16:0];
            prev_q[k_q]  <= PREV_W'(tg[k_q]);
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= ST_SMOOTH;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_SMOOTH: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q       <= 1'b0;
            base_q[k_q] <= snew;
            if (k_q == 2'd2) begin
              k_q     <= '0;
              phase_q <= phase_nx;
              ch_q    <= 1'b0;
              state_q <= ST_DIEL;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_DIEL: begin
          if (!run_q) run_q <= 1'b1;
          else if (div_done) begin
            run_q   <= 1'b0;
            k_q     <= '0;
            state_q <= ST_AMT;
          end
        end
        ST_AMT: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q <= 1'b0;
            if (k_q == 2'd1) begin
              k_q     <= '0;
              p_q     <= '0;
              state_q <= ST_PRD;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_PRD: begin
          state_q <= ST_POLE;
        end
        ST_POLE: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q       <= 1'b0;
            vld_q[addr] <= 1'b1;
            if (p_q == 3'd5) begin
              k_q     <= '0;
              state_q <= ST_MIX;
            end else begin
              p_q     <= p_q + 3'd1;
              state_q <= ST_PRD;
            end
          end
        end
        ST_MIX: begin
          if (!run_q) run_q <= 1'b1;
          else if (mul_done) begin
            run_q <= 1'b0;
            if (k_q == 2'd2) begin
              k_q <= '0;
              if (!ch_q) begin
                ch_q    <= 1'b1;
                state_q <= ST_DIEL;
              end else begin
                state_q <= ST_OUT;
              end
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        ST_OUT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working values of the item in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xs_q[0] <= in_i.left_in;
      xs_q[1] <= in_i.right_in;
      bs_q    <= in_i.block_start;
    end
    if (state_q == ST_TGT && run_q && mul_done) begin
      tgt_q[k_q[0]] <= 17'((mul_p + MP_W'(HALF_Q16)) >>> 16);
      lo_q          <= '0;
      hi_q          <= 19'(CBRT_HI);
    end
    if (state_q == ST_CUBE && run_q && mul_done) begin
      if (!cph_q) sq_q <= 36'(mul_p);
      else if ($unsigned(mul_p) <= (MP_W'(n16) << CBRT_SHIFT)) lo_q <= 19'(mid);
      else hi_q <= 19'(mid);
    end
    if (state_q == ST_TRIM && run_q && div_done) trim_q <= div_quo[TR_W-1:0];
    if (state_q == ST_DIEL && run_q && div_done) sc_q <= sc_new;
    if (state_q == ST_AMT && run_q && mul_done) begin
      amt_q[k_q[0]] <= SC_W'((mul_p + MP_W'(HALF_Q16)) >>> 16);
      xcur_q        <= POLE_W'(xs_q[ch_q]);
    end
    if (state_q == ST_POLE && run_q && mul_done) begin
      xcur_q <= which ? newy : xnext;
    end
    if (state_q == ST_MIX && run_q && mul_done) begin
      unique case (k_q)
        2'd0:    f_q   <= F_W'((mul_p + (MP_W'(1) <<< (CF - 1))) >>> CF);
        2'd1:    acc_q <= mul_p;
        default: res_q[ch_q] <= mres;
      endcase
    end
    if (out_load) begin
      out_l_q <= res_q[0];
      out_r_q <= res_q[1];
    end
  end

  // pole store: at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_POLE && run_q && mul_done) mem[addr] <= newy;
    if (state_q == ST_PRD) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdv_q <= 1'b0;
    else if (state_q == ST_PRD) rdv_q <= vld_q[addr];
  end
endmodule

FILE: rtl/srp_mul.sv
// bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle while busy
module srp_mul import srp_pkg::*; #(
  parameter int BW = MUL_B_MIN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [MUL_A_W-1:0]      a_i,
  input  logic        [BW-1:0]           b_i,
  output logic                           done_o,
  output logic signed [MUL_A_W+BW-1:0]   p_o
);
  localparam int CW = $clog2(BW + 1);

  logic signed [MUL_A_W:0]   hi_q, hi_d, sum;
  logic        [BW-1:0]      lo_q, lo_d;
  logic signed [MUL_A_W-1:0] a_q;
  logic                      busy_q, done_q;
  logic        [CW-1:0]      cnt_q;

  always_comb begin
    sum  = lo_q[0] ? hi_q + (MUL_A_W+1)'(a_q) : hi_q;
    hi_d = {sum[MUL_A_W], sum[MUL_A_W:1]};
    lo_d = {sum[0], lo_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = {hi_q[MUL_A_W-1:0], lo_q};
endmodule

FILE: rtl/srp_div.sv
// restoring divider, one quotient bit per cycle while busy
module srp_div import srp_pkg::*; #(
  parameter int NW = DIV_N_MIN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]      n_q, n_d;
  logic [DIV_D_W-1:0] rem_q, rem_d, den_q;
  logic [DIV_D_W:0]   t;
  logic               ge;
  logic               busy_q, done_q;
  logic [CW-1:0]      cnt_q;

  always_comb begin
    t     = {rem_q, n_q[NW-1]};
    ge    = t >= {1'b0, den_q};
    rem_d = ge ? DIV_D_W'(t - {1'b0, den_q}) : t[DIV_D_W-1:0];
    n_d   = {n_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q   <= n_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;
endmodule
